@@ rtl/jaccard_neighbor_similarity_core_defines.svh @@
// ----------------------------------------------------------------------------
// Jaccard neighbor similarity: assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef JACCARD_NEIGHBOR_SIMILARITY_CORE_DEFINES_SVH
`define JACCARD_NEIGHBOR_SIMILARITY_CORE_DEFINES_SVH

// same-cycle implication
`define JNSC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jnsc check failed");

// next-cycle implication
`define JNSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jnsc check failed");

`endif

@@ rtl/jnsc_pkg.sv @@
// ----------------------------------------------------------------------------
// jnsc_pkg
// Word types and fixed constants of the Jaccard neighbor similarity core.
// ----------------------------------------------------------------------------
`default_nettype none

package jnsc_pkg;

  localparam int ID_BITS         = 32;
  localparam int SCORE_FRAC_BITS = 16;
  localparam int SCORE_W         = SCORE_FRAC_BITS + 1;
  localparam int COMMON_W        = 11;
  localparam int UNION_W         = 12;

  localparam logic [1:0] CMD_SRC  = 2'd0;
  localparam logic [1:0] CMD_DST  = 2'd1;
  localparam logic [1:0] CMD_CALC = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [ID_BITS-1:0] neighbor_id;
    logic [ID_BITS-1:0] src_vertex;
    logic [ID_BITS-1:0] dst_vertex;
  } in_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0]  score_fixed;
    logic [COMMON_W-1:0] common_count;
    logic [UNION_W-1:0]  union_size;
    logic                overflowed;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/jnsc_ram.sv @@
// ----------------------------------------------------------------------------
// jnsc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module jnsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr,
  output logic      [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/jaccard_neighbor_similarity_core.sv @@
// ----------------------------------------------------------------------------
// jaccard_neighbor_similarity_core
// Jaccard index of two neighbor lists held in RAM, unsigned Q1.16 result.
// ----------------------------------------------------------------------------
//  channel | direction | word       | accepted when
//  in_     | input     | in_word_t  | in_valid  && !in_stall
//  out_    | output    | out_word_t | out_valid && !out_stall
//
//  Compute runs the dedup and match scans over list fills S and D, through
//  one RAM read port per list, and then the bit-serial divider.
//  Reset (synchronous, rst_n low) empties both lists and the overflow flag;
//  RAM contents are not cleared. Input is stalled for the whole compute; a
//  stalled result holds the next finished compute in its last state, with
//  input still stalled; appends are taken only while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module jaccard_neighbor_similarity_core
  import jnsc_pkg::*;
#(
  parameter int MAX_DEGREE = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam int AW     = $clog2(MAX_DEGREE);
  localparam int CW     = $clog2(MAX_DEGREE + 1);
  localparam int UW     = CW + 1;
  localparam int RW     = UW + 1;
  localparam int STEP_W = $clog2(SCORE_FRAC_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_KEY, ST_DUP, ST_DUPCHK,
    ST_CMP, ST_CMPCHK, ST_PREP, ST_DIV, ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       src_fill_r, src_fill_nxt, dst_fill_r, dst_fill_nxt;
  logic                ovf_r, ovf_nxt;
  logic                lst_r, lst_nxt;
  logic [CW-1:0]       i_r, i_nxt, j_r, j_nxt;
  logic [ID_BITS-1:0]  key_r, key_nxt;
  logic [ID_BITS-1:0]  self_src_r, self_src_nxt, self_dst_r, self_dst_nxt;
  logic [CW-1:0]       src_cnt_r, src_cnt_nxt, dst_cnt_r, dst_cnt_nxt;
  logic [CW-1:0]       com_r, com_nxt;
  logic [UW-1:0]       uni_r, uni_nxt;
  logic [RW-1:0]       rem_r, rem_nxt, rem_diff;
  logic [SCORE_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_r, out_nxt;

  logic                src_we, dst_we;
  logic [AW-1:0]       rd_addr;
  logic [ID_BITS-1:0]  src_rdata, dst_rdata, cur_data, cur_self;
  logic [CW-1:0]       cur_fill;
  logic                qbit;

  jnsc_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_DEGREE)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_fill_r[AW-1:0]),
    .wdata (in_word.neighbor_id),
    .raddr (rd_addr),
    .rdata (src_rdata)
  );

  jnsc_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_DEGREE)) u_dst_ram (
    .clk   (clk),
    .we    (dst_we),
    .waddr (dst_fill_r[AW-1:0]),
    .wdata (in_word.neighbor_id),
    .raddr (rd_addr),
    .rdata (dst_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign src_we = in_valid && (state_r == ST_IDLE) && (in_word.cmd == CMD_SRC) &&
                  (src_fill_r != CW'(MAX_DEGREE));
  assign dst_we = in_valid && (state_r == ST_IDLE) && (in_word.cmd == CMD_DST) &&
                  (dst_fill_r != CW'(MAX_DEGREE));

  assign cur_fill = lst_r ? dst_fill_r : src_fill_r;
  assign cur_self = lst_r ? self_dst_r : self_src_r;
  assign cur_data = lst_r ? dst_rdata  : src_rdata;
  assign qbit     = (rem_r >= RW'(uni_r));
  assign rem_diff = qbit ? (rem_r - RW'(uni_r)) : rem_r;

  always_comb begin
    state_nxt     = state_r;
    src_fill_nxt  = src_fill_r;
    dst_fill_nxt  = dst_fill_r;
    ovf_nxt       = ovf_r;
    lst_nxt       = lst_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    key_nxt       = key_r;
    self_src_nxt  = self_src_r;
    self_dst_nxt  = self_dst_r;
    src_cnt_nxt   = src_cnt_r;
    dst_cnt_nxt   = dst_cnt_r;
    com_nxt       = com_r;
    uni_nxt       = uni_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    rd_addr       = i_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_word.cmd)
            CMD_SRC: begin
              if (src_fill_r == CW'(MAX_DEGREE)) ovf_nxt = 1'b1;
              else src_fill_nxt = src_fill_r + CW'(1);
            end
            CMD_DST: begin
              if (dst_fill_r == CW'(MAX_DEGREE)) ovf_nxt = 1'b1;
              else dst_fill_nxt = dst_fill_r + CW'(1);
            end
            CMD_CALC: begin
              self_src_nxt = in_word.src_vertex;
              self_dst_nxt = in_word.dst_vertex;
              lst_nxt      = 1'b0;
              i_nxt        = '0;
              src_cnt_nxt  = '0;
              dst_cnt_nxt  = '0;
              com_nxt      = '0;
              state_nxt    = ST_FETCH;
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        if (i_r == cur_fill) begin
          if (!lst_r) begin
            lst_nxt = 1'b1;
            i_nxt   = '0;
          end else begin
            state_nxt = ST_PREP;
          end
        end else begin
          rd_addr   = i_r[AW-1:0];
          state_nxt = ST_KEY;
        end
      end
      ST_KEY: begin
        key_nxt = cur_data;
        if (cur_data == cur_self) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_FETCH;
        end else begin
          j_nxt     = '0;
          state_nxt = ST_DUP;
        end
      end
      ST_DUP: begin
        if (j_r == i_r) begin
          if (lst_r) begin
            dst_cnt_nxt = dst_cnt_r + CW'(1);
            i_nxt       = i_r + CW'(1);
            state_nxt   = ST_FETCH;
          end else begin
            src_cnt_nxt = src_cnt_r + CW'(1);
            j_nxt       = '0;
            state_nxt   = ST_CMP;
          end
        end else begin
          rd_addr   = j_r[AW-1:0];
          state_nxt = ST_DUPCHK;
        end
      end
      ST_DUPCHK: begin
        if (cur_data == key_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_FETCH;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_DUP;
        end
      end
      ST_CMP: begin
        if (j_r == dst_fill_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_FETCH;
        end else begin
          rd_addr   = j_r[AW-1:0];
          state_nxt = ST_CMPCHK;
        end
      end
      ST_CMPCHK: begin
        if (dst_rdata == key_r) begin
          if (key_r != self_dst_r) com_nxt = com_r + CW'(1);
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_FETCH;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_CMP;
        end
      end
      ST_PREP: begin
        uni_nxt  = UW'(src_cnt_r) + UW'(dst_cnt_r) - UW'(com_r);
        rem_nxt  = RW'(com_r);
        step_nxt = '0;
        if ((src_cnt_r == '0) && (dst_cnt_r == '0)) begin
          quo_nxt   = SCORE_W'(1) << SCORE_FRAC_BITS;
          state_nxt = ST_DONE;
        end else if ((src_cnt_r == '0) || (dst_cnt_r == '0)) begin
          quo_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          quo_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt  = {quo_r[SCORE_W-2:0], qbit};
        rem_nxt  = rem_diff << 1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SCORE_FRAC_BITS)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.score_fixed  = quo_r;
          out_nxt.common_count = COMMON_W'(com_r);
          out_nxt.union_size   = UNION_W'(uni_r);
          out_nxt.overflowed   = ovf_r;
          src_fill_nxt         = '0;
          dst_fill_nxt         = '0;
          ovf_nxt              = 1'b0;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      src_fill_r  <= '0;
      dst_fill_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      src_fill_r  <= src_fill_nxt;
      dst_fill_r  <= dst_fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lst_r      <= lst_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    key_r      <= key_nxt;
    self_src_r <= self_src_nxt;
    self_dst_r <= self_dst_nxt;
    src_cnt_r  <= src_cnt_nxt;
    dst_cnt_r  <= dst_cnt_nxt;
    com_r      <= com_nxt;
    uni_r      <= uni_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    out_r      <= out_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/jnsc_checker.sv @@
// ----------------------------------------------------------------------------
// jnsc_checker
// Port-level checks of the Jaccard neighbor similarity core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jaccard_neighbor_similarity_core_defines.svh"

module jnsc_checker
  import jnsc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  localparam logic [SCORE_W-1:0] ONE_Q = SCORE_W'(1) << SCORE_FRAC_BITS;

  `JNSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `JNSC_ASSERT_NOW(a_score_max, out_valid, out_word.score_fixed <= ONE_Q)
  `JNSC_ASSERT_NOW(a_common_le_union, out_valid, UNION_W'(out_word.common_count) <= out_word.union_size)
  `JNSC_ASSERT_NOW(a_empty_is_one, out_valid && (out_word.union_size == '0), out_word.score_fixed == ONE_Q)

endmodule

bind jaccard_neighbor_similarity_core jnsc_checker u_jnsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
